[rtl/core/bml_pkg.sv]
// Package: shared constants and types of the traffic grid step unit.
`timescale 1ns / 1ps
package bml_pkg;
  localparam int unsigned MaxSideDefault = 64;
  localparam int unsigned SizeW = 7;

  typedef enum logic [1:0] {
    FuncWrite = 2'd0,
    FuncStep  = 2'd1,
    FuncRead  = 2'd2,
    FuncNop   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CellEmpty = 2'd0,
    CellLr    = 2'd1,
    CellTb    = 2'd2,
    CellBad   = 2'd3
  } cell_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSweep,
    StDone
  } state_e;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] cell_value;
  } req_t;

  typedef struct packed {
    logic [1:0] cell_state;
    logic       out_of_range;
  } rsp_t;
endpackage

[rtl/core/bml_if.sv]
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps
interface bml_req_if;
  logic           valid;
  logic           ready;
  bml_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bml_rsp_if;
  logic           valid;
  logic           ready;
  bml_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/bml_traffic_grid_step_unit.sv]
// Top level: traffic grid held in two memories, swept cell by cell per step.
//
// Write, flagged and no-op items answer the cycle after they are taken. A read
// answers after the registered memory read returns its data. No new item is
// taken while a read is pending or a response waits. A step sweeps the n by n
// grid twice. Each cell is handled in steps: reads of self, previous and next
// cell on the single read port, then the write, so the read port sets the pace
// of a step. After reset the grid memory is cleared one cell per cycle, all
// 2**(2*clog2(MAX_SIDE)) cells (4096 at the default size), before the first
// item is taken. Write the configuration only while no item is in flight.
`timescale 1ns / 1ps
module bml_traffic_grid_step_unit #(
  parameter int unsigned MAX_SIDE = bml_pkg::MaxSideDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bml_pkg::SizeW-1:0] cfg_wdata_i,
  bml_req_if.sink                   req,
  bml_rsp_if.source                 rsp
);
  import bml_pkg::*;

  localparam int unsigned AW = 2 * $clog2(MAX_SIDE);
  localparam int unsigned IW = $clog2(MAX_SIDE);
  localparam int unsigned DEPTH = 1 << AW;

  logic [1:0] grid_mem [DEPTH];
  logic [1:0] scr_mem  [DEPTH];

  logic [SizeW-1:0] size_q;
  logic [IW:0]      n;
  state_e           state_q, state_d;
  logic             rsp_valid_q, rsp_valid_d;
  rsp_t             rsp_q, rsp_d;
  req_t             req_q, req_d;
  logic             phase_q, phase_d;      // 0: LR grid->scratch, 1: TB scratch->grid
  logic [1:0]       sub_q, sub_d;          // 0 self, 1 prev, 2 next + write, 3 advance
  logic [IW-1:0]    r_q, r_d, c_q, c_d;
  logic [1:0]       self_q, self_d, prv_q, prv_d;
  logic [AW:0]      clr_q, clr_d;
  logic             busy_q, busy_d;       // read data pending

  logic [AW-1:0]    rd_addr, wr_addr;
  logic             rd_scr, we_grid, we_scr;
  logic [1:0]       wr_data, rd_q;
  logic             rd_scr_q;
  logic [1:0]       grid_rd_q, scr_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) size_q <= SizeW'(64);
    else if (cfg_we_i) size_q <= cfg_wdata_i;
  end

  assign n = (32'(size_q) > MAX_SIDE) ? (IW+1)'(MAX_SIDE) : (IW+1)'(size_q);

  always_ff @(posedge clk_i) begin
    if (we_grid) grid_mem[wr_addr] <= wr_data;
    if (we_scr) scr_mem[wr_addr] <= wr_data;
    grid_rd_q <= grid_mem[rd_addr];
    scr_rd_q  <= scr_mem[rd_addr];
    rd_scr_q  <= rd_scr;
  end
  assign rd_q = rd_scr_q ? scr_rd_q : grid_rd_q;

  function automatic logic [AW-1:0] cat(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return {r, c};
  endfunction

  logic [IW-1:0] rp, rn, cp, cn, last;
  logic [1:0]    kind, newv;
  assign last = IW'(n - 1'b1);
  assign rp = (r_q == '0) ? last : r_q - 1'b1;
  assign rn = (r_q == last) ? '0 : r_q + 1'b1;
  assign cp = (c_q == '0) ? last : c_q - 1'b1;
  assign cn = (c_q == last) ? '0 : c_q + 1'b1;
  assign kind = phase_q ? CellTb : CellLr;

  always_comb begin
    if (prv_q == kind && self_q == CellEmpty) newv = kind;
    else if (self_q == kind && rd_q == CellEmpty) newv = CellEmpty;
    else newv = self_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; rsp_valid_q <= 1'b0; clr_q <= '0; busy_q <= 1'b0;
      phase_q <= 1'b0; sub_q <= '0; r_q <= '0; c_q <= '0;
    end else begin
      state_q <= state_d; rsp_valid_q <= rsp_valid_d; clr_q <= clr_d; busy_q <= busy_d;
      phase_q <= phase_d; sub_q <= sub_d; r_q <= r_d; c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d; req_q <= req_d; self_q <= self_d; prv_q <= prv_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == (AW+1)'(DEPTH - 1)) state_d = StIdle;
      StIdle:  if (req.valid && req.ready && req.payload.func == FuncStep && n != '0)
                 state_d = StSweep;
      StSweep: if (sub_q == 2'd3 && r_q == last && c_q == last && phase_q)
                 state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d = rsp_q;
    req_d = req_q;
    clr_d = clr_q;
    busy_d = 1'b0;
    phase_d = phase_q; sub_d = sub_q; r_d = r_q; c_d = c_q;
    self_d = self_q; prv_d = prv_q;
    rd_addr = cat(r_q, c_q); rd_scr = 1'b0;
    we_grid = 1'b0; we_scr = 1'b0; wr_addr = cat(r_q, c_q); wr_data = newv;
    req.ready = 1'b0;
    if (rsp.valid && rsp.ready) rsp_valid_d = 1'b0;
    unique case (state_q)
      StClear: begin
        we_grid = 1'b1; wr_addr = clr_q[AW-1:0]; wr_data = CellEmpty;
        clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        rd_addr = cat(IW'(req_q.row), IW'(req_q.col));
        if (busy_q) begin
          // read data for a pending read arrives now
          rsp_valid_d = 1'b1;
          rsp_d.cell_state = rd_q;
          rsp_d.out_of_range = 1'b0;
        end else begin
          req.ready = !rsp_valid_q;
          if (req.valid && req.ready) begin
            req_d = req.payload;
            r_d = '0; c_d = '0; sub_d = '0; phase_d = 1'b0;
            rsp_d = '0;
            unique case (req.payload.func)
              FuncWrite, FuncRead: begin
                if (32'(req.payload.row) >= 32'(n) || 32'(req.payload.col) >= 32'(n)) begin
                  rsp_d.out_of_range = 1'b1; rsp_valid_d = 1'b1;
                end else if (req.payload.func == FuncRead) begin
                  busy_d = 1'b1;
                  rd_addr = cat(IW'(req.payload.row), IW'(req.payload.col));
                end else begin
                  we_grid = 1'b1;
                  wr_addr = cat(IW'(req.payload.row), IW'(req.payload.col));
                  wr_data = (req.payload.cell_value == CellBad) ? CellEmpty
                                                                 : req.payload.cell_value;
                  rsp_valid_d = 1'b1;
                end
              end
              FuncStep: begin
                rsp_valid_d = (n == '0);
                rd_addr = '0;   // self of cell (0,0), phase 0 reads grid
              end
              default: rsp_valid_d = 1'b1;
            endcase
          end
        end
      end
      StSweep: begin
        rd_scr = phase_q;
        // sub 0: self read issued last cycle -> capture, issue prev
        // sub 1: prev data -> capture, issue next
        // sub 2: next data -> write
        // sub 3: advance, issue following self
        unique case (sub_q)
          2'd0: begin
            self_d = rd_q;
            rd_addr = phase_q ? cat(rp, c_q) : cat(r_q, cp);
            sub_d = 2'd1;
          end
          2'd1: begin
            prv_d = rd_q;
            rd_addr = phase_q ? cat(rn, c_q) : cat(r_q, cn);
            sub_d = 2'd2;
          end
          2'd2: begin
            // rd_q holds next cell now; write result
            we_scr = !phase_q; we_grid = phase_q;
            sub_d = 2'd3;
          end
          default: begin
            // advance to following cell and issue its self read
            sub_d = 2'd0;
            if (c_q == last) begin
              c_d = '0;
              if (r_q == last) begin
                r_d = '0;
                if (phase_q) rsp_valid_d = 1'b1;
                phase_d = 1'b1;
              end else r_d = r_q + 1'b1;
            end else c_d = c_q + 1'b1;
            rd_addr = cat(r_d, c_d);
            rd_scr = phase_d;
          end
        endcase
      end
      default: ;
    endcase
  end

  // next-cell read data must survive the write cycle: sub 2 uses rd_q directly
  assign rsp.valid = rsp_valid_q;
  assign rsp.payload = rsp_q;
endmodule
